// ----- rtl/core/lsrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment clipper package
// Shared constants, register indexes and edge codes of the segment clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;

	localparam int COORD_BITS_DEF = 32;

	// Configuration register indexes.
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	// Rectangle edges, in the order in which they are tried.
	localparam logic [1:0] E_TOP    = 2'd0;
	localparam logic [1:0] E_RIGHT  = 2'd1;
	localparam logic [1:0] E_BOTTOM = 2'd2;
	localparam logic [1:0] E_LEFT   = 2'd3;

	// Width of one queue item for a given coordinate width.
	function automatic int ent_bits(input int w);
		return 10 * w + 16;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lsrc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment clipper queue
// Two-entry queue between the classification front and the division back.
// ----------------------------------------------------------------------------
module lsrc_fifo #(
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	output logic [DW-1:0]      rd_data,
	output logic               full,
	output logic               empty
);
	logic [DW-1:0] mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (rd_en) begin
				rp_q <= ~rp_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lsrc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment clipper front
// Orders endpoints, runs the reject and interior tests and the exact edge
// intersection tests, and picks the edges that replace outside endpoints.
// ----------------------------------------------------------------------------
module lsrc_front import lsrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic signed [COORD_BITS-1:0] rect_left,
	input  wire logic signed [COORD_BITS-1:0] rect_bottom,
	input  wire logic signed [COORD_BITS-1:0] rect_right,
	input  wire logic signed [COORD_BITS-1:0] rect_top,
	output logic                              q_wr,
	output logic [ent_bits(COORD_BITS)-1:0]   q_data,
	input  wire logic                         q_full
);
	localparam int W = COORD_BITS;
	localparam int P = 2 * W + 2;
	localparam int N = 2 * W + 3;

	typedef struct packed {
		logic                vis;
		logic                swp;
		logic signed [W-1:0] sx;
		logic signed [W-1:0] sy;
		logic signed [W-1:0] ex;
		logic signed [W-1:0] ey;
		logic                st_edge;
		logic [1:0]          st_idx;
		logic                en_edge;
		logic [1:0]          en_idx;
		logic signed [N-1:0] st_num;
		logic signed [N-1:0] en_num;
		logic signed [W:0]   st_den;
		logic signed [W:0]   en_den;
	} ent_t;

	typedef struct packed {
		logic                swp;
		logic signed [W-1:0] sx;
		logic signed [W-1:0] sy;
		logic signed [W-1:0] ex;
		logic signed [W-1:0] ey;
		logic signed [W:0]   dx;
		logic signed [W:0]   dy;
		logic                rej;
		logic                ins_s;
		logic                ins_e;
		logic                below;
	} car_t;

	function automatic logic signed [W:0] sx1(input logic signed [W-1:0] v);
		return {v[W-1], v};
	endfunction

	logic adv;

	// Stage 1: ordered endpoints.
	logic                v_s1, swp_s1;
	logic signed [W-1:0] sx_s1, sy_s1, ex_s1, ey_s1;

	// Stage 2: differences and range checks.
	logic              v_s2;
	car_t              car_s2;
	logic signed [W:0] t_s2 [4];
	logic signed [W:0] u_s2 [4];
	logic signed [W:0] d1_s2 [4];
	logic [3:0]        prj_s2;

	// Stage 3: products.
	logic              v_s3;
	car_t              car_s3;
	logic signed [P-1:0] p1_s3 [4];
	logic signed [P-1:0] p2_s3 [4];
	logic signed [P-1:0] den_s3 [4];
	logic [3:0]          prj_s3;

	// Stage 4: numerators and hit flags.
	logic                v_s4;
	car_t                car_s4;
	logic signed [N-1:0] num_s4 [4];
	logic [3:0]          hit_s4;

	assign busy = v_s4 && q_full;
	assign adv  = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1.
	always_ff @(posedge clk) begin
		if (adv) begin
			swp_s1 <= (end_y < start_y);
			if (end_y < start_y) begin
				sx_s1 <= end_x;
				sy_s1 <= end_y;
				ex_s1 <= start_x;
				ey_s1 <= start_y;
			end else begin
				sx_s1 <= start_x;
				sy_s1 <= start_y;
				ex_s1 <= end_x;
				ey_s1 <= end_y;
			end
		end
	end

	// Stage 2 logic.
	logic signed [W-1:0] ef [4], ea0 [4], ea1 [4], esf [4], esa [4];
	logic signed [W:0]   edf [4];
	logic signed [W:0]   dx_c, dy_c;
	logic signed [W:0]   t_c [4], u_c [4], d1_c [4];
	logic [3:0]          prj_c;
	logic                rej_c, ins_s_c, ins_e_c;

	always_comb begin
		dx_c = sx1(ex_s1) - sx1(sx_s1);
		dy_c = sx1(ey_s1) - sx1(sy_s1);

		ef[E_TOP]     = rect_top;    ea0[E_TOP]    = rect_left;
		ea1[E_TOP]    = rect_right;  esf[E_TOP]    = sy_s1;
		esa[E_TOP]    = sx_s1;       edf[E_TOP]    = dy_c;
		ef[E_RIGHT]   = rect_right;  ea0[E_RIGHT]  = rect_top;
		ea1[E_RIGHT]  = rect_bottom; esf[E_RIGHT]  = sx_s1;
		esa[E_RIGHT]  = sy_s1;       edf[E_RIGHT]  = dx_c;
		ef[E_BOTTOM]  = rect_bottom; ea0[E_BOTTOM] = rect_right;
		ea1[E_BOTTOM] = rect_left;   esf[E_BOTTOM] = sy_s1;
		esa[E_BOTTOM] = sx_s1;       edf[E_BOTTOM] = dy_c;
		ef[E_LEFT]    = rect_left;   ea0[E_LEFT]   = rect_bottom;
		ea1[E_LEFT]   = rect_top;    esf[E_LEFT]   = sx_s1;
		esa[E_LEFT]   = sy_s1;       edf[E_LEFT]   = dx_c;

		for (int k = 0; k < 4; k++) begin
			t_c[k]  = sx1(ef[k]) - sx1(esf[k]);
			u_c[k]  = sx1(ea0[k]) - sx1(esa[k]);
			d1_c[k] = sx1(ea1[k]) - sx1(ea0[k]);
			if (edf[k] == '0 || d1_c[k] == '0) begin
				prj_c[k] = 1'b1;
			end else if (edf[k] > 0) begin
				prj_c[k] = (t_c[k] < 0) || (t_c[k] > edf[k]);
			end else begin
				prj_c[k] = (t_c[k] > 0) || (t_c[k] < edf[k]);
			end
		end

		rej_c = (sy_s1 > rect_top) || (ey_s1 < rect_bottom);
		if (ex_s1 >= sx_s1) begin
			rej_c = rej_c || (sx_s1 > rect_right) || (ex_s1 < rect_left);
		end else begin
			rej_c = rej_c || (sx_s1 < rect_left) || (ex_s1 > rect_right);
		end
		ins_s_c = (rect_right > sx_s1) && (rect_left < sx_s1) &&
			(rect_top > sy_s1) && (rect_bottom < sy_s1);
		ins_e_c = (rect_right > ex_s1) && (rect_left < ex_s1) &&
			(rect_top > ey_s1) && (rect_bottom < ey_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s2.swp   <= swp_s1;
			car_s2.sx    <= sx_s1;
			car_s2.sy    <= sy_s1;
			car_s2.ex    <= ex_s1;
			car_s2.ey    <= ey_s1;
			car_s2.dx    <= dx_c;
			car_s2.dy    <= dy_c;
			car_s2.rej   <= rej_c;
			car_s2.ins_s <= ins_s_c;
			car_s2.ins_e <= ins_e_c;
			car_s2.below <= (sy_s1 < rect_bottom);
			t_s2         <= t_c;
			u_s2         <= u_c;
			d1_s2        <= d1_c;
			prj_s2       <= prj_c;
		end
	end

	// Stage 3: edge-side delta times offsets, and the determinant.
	always_ff @(posedge clk) begin
		if (adv) begin
			car_s3 <= car_s2;
			prj_s3 <= prj_s2;
			for (int k = 0; k < 4; k++) begin
				if (k == E_TOP || k == E_BOTTOM) begin
					p1_s3[k]  <= P'(car_s2.dx) * P'(t_s2[k]);
					p2_s3[k]  <= P'(car_s2.dy) * P'(u_s2[k]);
					den_s3[k] <= P'(car_s2.dy) * P'(d1_s2[k]);
				end else begin
					p1_s3[k]  <= P'(car_s2.dy) * P'(t_s2[k]);
					p2_s3[k]  <= P'(car_s2.dx) * P'(u_s2[k]);
					den_s3[k] <= P'(car_s2.dx) * P'(d1_s2[k]);
				end
			end
		end
	end

	// Stage 4: the edge parameter must lie within [0,1].
	logic signed [N-1:0] num_c [4];
	logic signed [N-1:0] den_c [4];
	logic [3:0]          hit_c;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			num_c[k] = N'(p1_s3[k]) - N'(p2_s3[k]);
			den_c[k] = N'(den_s3[k]);
			if (den_c[k] >= 0) begin
				hit_c[k] = !prj_s3[k] && (num_c[k] >= 0) && (num_c[k] <= den_c[k]);
			end else begin
				hit_c[k] = !prj_s3[k] && (num_c[k] <= 0) && (num_c[k] >= den_c[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s4 <= car_s3;
			num_s4 <= num_c;
			hit_s4 <= hit_c;
		end
	end

	// Endpoint selection.
	ent_t       ent;
	logic [1:0] first4;
	logic       any4;

	always_comb begin
		any4 = |hit_s4;
		if (hit_s4[E_TOP]) begin
			first4 = E_TOP;
		end else if (hit_s4[E_RIGHT]) begin
			first4 = E_RIGHT;
		end else if (hit_s4[E_BOTTOM]) begin
			first4 = E_BOTTOM;
		end else begin
			first4 = E_LEFT;
		end

		ent         = '0;
		ent.swp     = car_s4.swp;
		ent.sx      = car_s4.sx;
		ent.sy      = car_s4.sy;
		ent.ex      = car_s4.ex;
		ent.ey      = car_s4.ey;
		ent.st_idx  = E_TOP;
		ent.en_idx  = E_TOP;

		if (!car_s4.rej) begin
			if (car_s4.ins_s) begin
				if (car_s4.ins_e) begin
					ent.vis = 1'b1;
				end else begin
					ent.vis     = any4;
					ent.en_edge = 1'b1;
					ent.en_idx  = first4;
				end
			end else if (car_s4.ins_e) begin
				ent.vis     = any4;
				ent.st_edge = 1'b1;
				ent.st_idx  = first4;
			end else if (car_s4.below && hit_s4[E_BOTTOM]) begin
				ent.st_edge = 1'b1;
				ent.st_idx  = E_BOTTOM;
				ent.en_edge = 1'b1;
				ent.vis     = hit_s4[E_TOP] || hit_s4[E_LEFT] || hit_s4[E_RIGHT];
				if (hit_s4[E_TOP]) begin
					ent.en_idx = E_TOP;
				end else if (hit_s4[E_LEFT]) begin
					ent.en_idx = E_LEFT;
				end else begin
					ent.en_idx = E_RIGHT;
				end
			end else if (hit_s4[E_LEFT]) begin
				ent.st_edge = 1'b1;
				ent.st_idx  = E_LEFT;
				ent.en_edge = 1'b1;
				ent.vis     = hit_s4[E_TOP] || hit_s4[E_RIGHT];
				ent.en_idx  = hit_s4[E_TOP] ? E_TOP : E_RIGHT;
			end else if (hit_s4[E_RIGHT]) begin
				ent.st_edge = 1'b1;
				ent.st_idx  = E_RIGHT;
				ent.en_edge = 1'b1;
				ent.vis     = hit_s4[E_TOP] || hit_s4[E_LEFT];
				ent.en_idx  = hit_s4[E_TOP] ? E_TOP : E_LEFT;
			end
		end

		// The divisor is the segment delta along the edge's fixed axis.
		ent.st_num = num_s4[ent.st_idx];
		ent.en_num = num_s4[ent.en_idx];
		ent.st_den = (ent.st_idx == E_TOP || ent.st_idx == E_BOTTOM) ?
			car_s4.dy : car_s4.dx;
		ent.en_den = (ent.en_idx == E_TOP || ent.en_idx == E_BOTTOM) ?
			car_s4.dy : car_s4.dx;
	end

	assign q_wr   = v_s4 && adv;
	assign q_data = ent;

endmodule
`default_nettype wire

// ----- rtl/core/lsrc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment clipper divider
// Pipelined restoring divider, one quotient bit per stage, truncating
// toward zero. The quotient magnitude is known to fit in COORD_BITS bits.
// ----------------------------------------------------------------------------
module lsrc_div import lsrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic signed [2*COORD_BITS+2:0] num,
	input  wire logic signed [COORD_BITS:0]     den,
	output logic signed [COORD_BITS:0]          quo
);
	localparam int W  = COORD_BITS;
	localparam int N  = 2 * W + 3;
	localparam int QB = W;
	localparam int RW = 2 * W + 1;

	logic [RW-1:0] rem_s [QB+1];
	logic [W:0]    md_s  [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic          neg_s [QB+1];

	logic [N-1:0] abs_n;
	logic [W:0]   abs_d;

	assign abs_n = num[N-1] ? N'(-num) : N'(num);
	assign abs_d = den[W] ? (W+1)'(-den) : (W+1)'(den);

	always_ff @(posedge clk) begin
		rem_s[0] <= abs_n[RW-1:0];
		md_s[0]  <= abs_d;
		q_s[0]   <= '0;
		neg_s[0] <= num[N-1] ^ den[W];
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic [RW-1:0] trial;
		assign trial = RW'(md_s[k]) << B;
		always_ff @(posedge clk) begin
			md_s[k+1]  <= md_s[k];
			neg_s[k+1] <= neg_s[k];
			if (rem_s[k] >= trial) begin
				rem_s[k+1] <= rem_s[k] - trial;
				q_s[k+1]   <= q_s[k] | (QB'(1) << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				q_s[k+1]   <= q_s[k];
			end
		end
	end

	logic signed [W:0] qx;
	assign qx  = {1'b0, q_s[QB]};
	assign quo = neg_s[QB] ? -qx : qx;

endmodule
`default_nettype wire

// ----- rtl/core/lsrc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment clipper back
// Takes queued items, divides out the hit points on the chosen edges and
// drives the result registers.
// ----------------------------------------------------------------------------
module lsrc_back import lsrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ent_bits(COORD_BITS)-1:0] q_data,
	input  wire logic                         q_empty,
	output logic                              q_rd,
	input  wire logic signed [COORD_BITS-1:0] rect_left,
	input  wire logic signed [COORD_BITS-1:0] rect_bottom,
	input  wire logic signed [COORD_BITS-1:0] rect_right,
	input  wire logic signed [COORD_BITS-1:0] rect_top,
	output logic                              done,
	output logic                              visible,
	output logic signed [COORD_BITS-1:0]      clipped_start_x,
	output logic signed [COORD_BITS-1:0]      clipped_start_y,
	output logic signed [COORD_BITS-1:0]      clipped_end_x,
	output logic signed [COORD_BITS-1:0]      clipped_end_y
);
	localparam int W  = COORD_BITS;
	localparam int N  = 2 * W + 3;
	localparam int QB = W;

	typedef struct packed {
		logic                vis;
		logic                swp;
		logic signed [W-1:0] sx;
		logic signed [W-1:0] sy;
		logic signed [W-1:0] ex;
		logic signed [W-1:0] ey;
		logic                st_edge;
		logic [1:0]          st_idx;
		logic                en_edge;
		logic [1:0]          en_idx;
		logic signed [N-1:0] st_num;
		logic signed [N-1:0] en_num;
		logic signed [W:0]   st_den;
		logic signed [W:0]   en_den;
	} ent_t;

	typedef struct packed {
		logic                vis;
		logic                swp;
		logic signed [W-1:0] sx;
		logic signed [W-1:0] sy;
		logic signed [W-1:0] ex;
		logic signed [W-1:0] ey;
		logic                st_edge;
		logic [1:0]          st_idx;
		logic                en_edge;
		logic [1:0]          en_idx;
	} meta_t;

	ent_t ent;
	assign ent  = ent_t'(q_data);
	assign q_rd = !q_empty;

	logic  vld_s  [QB+1];
	meta_t meta_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= !q_empty;
			for (int k = 0; k < QB; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0].vis     <= ent.vis;
		meta_s[0].swp     <= ent.swp;
		meta_s[0].sx      <= ent.sx;
		meta_s[0].sy      <= ent.sy;
		meta_s[0].ex      <= ent.ex;
		meta_s[0].ey      <= ent.ey;
		meta_s[0].st_edge <= ent.st_edge;
		meta_s[0].st_idx  <= ent.st_idx;
		meta_s[0].en_edge <= ent.en_edge;
		meta_s[0].en_idx  <= ent.en_idx;
		for (int k = 0; k < QB; k++) begin
			meta_s[k+1] <= meta_s[k];
		end
	end

	logic signed [W:0] st_q, en_q;

	lsrc_div #(.COORD_BITS(COORD_BITS)) u_div_st (
		.clk (clk),
		.num (ent.st_num),
		.den (ent.st_den),
		.quo (st_q)
	);

	lsrc_div #(.COORD_BITS(COORD_BITS)) u_div_en (
		.clk (clk),
		.num (ent.en_num),
		.den (ent.en_den),
		.quo (en_q)
	);

	meta_t               m;
	logic signed [W-1:0] stx, sty, enx, eny;
	logic signed [W-1:0] st_a, en_a;

	assign m = meta_s[QB];

	always_comb begin
		// Points on the start and end edges.
		unique case (m.st_idx)
			E_TOP:    st_a = W'(rect_left + st_q);
			E_RIGHT:  st_a = W'(rect_top + st_q);
			E_BOTTOM: st_a = W'(rect_right + st_q);
			default:  st_a = W'(rect_bottom + st_q);
		endcase
		unique case (m.en_idx)
			E_TOP:    en_a = W'(rect_left + en_q);
			E_RIGHT:  en_a = W'(rect_top + en_q);
			E_BOTTOM: en_a = W'(rect_right + en_q);
			default:  en_a = W'(rect_bottom + en_q);
		endcase

		stx = m.sx;
		sty = m.sy;
		if (m.st_edge) begin
			unique case (m.st_idx)
				E_TOP:    begin stx = st_a;       sty = rect_top;    end
				E_RIGHT:  begin stx = rect_right; sty = st_a;        end
				E_BOTTOM: begin stx = st_a;       sty = rect_bottom; end
				default:  begin stx = rect_left;  sty = st_a;        end
			endcase
		end
		enx = m.ex;
		eny = m.ey;
		if (m.en_edge) begin
			unique case (m.en_idx)
				E_TOP:    begin enx = en_a;       eny = rect_top;    end
				E_RIGHT:  begin enx = rect_right; eny = en_a;        end
				E_BOTTOM: begin enx = en_a;       eny = rect_bottom; end
				default:  begin enx = rect_left;  eny = en_a;        end
			endcase
		end
	end

	logic done_q, visible_q;
	logic signed [W-1:0] csx_q, csy_q, cex_q, cey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			visible_q <= 1'b0;
		end else begin
			done_q    <= vld_s[QB];
			visible_q <= vld_s[QB] && m.vis;
		end
	end

	always_ff @(posedge clk) begin
		if (!m.vis) begin
			csx_q <= '0;
			csy_q <= '0;
			cex_q <= '0;
			cey_q <= '0;
		end else if (m.swp) begin
			csx_q <= enx;
			csy_q <= eny;
			cex_q <= stx;
			cey_q <= sty;
		end else begin
			csx_q <= stx;
			csy_q <= sty;
			cex_q <= enx;
			cey_q <= eny;
		end
	end

	assign done            = done_q;
	assign visible         = visible_q;
	assign clipped_start_x = csx_q;
	assign clipped_start_y = csy_q;
	assign clipped_end_x   = cex_q;
	assign clipped_end_y   = cey_q;

endmodule
`default_nettype wire

// ----- rtl/core/line_segment_rect_clipper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line segment rectangle clipper
// Clips one Q16.16 line segment per cycle, while busy is low, against an axis-aligned rectangle.
// ----------------------------------------------------------------------------
// Usage:
// The rectangle corners are written through cfg_we / cfg_idx / cfg_wdata
// (index 0 left, 1 bottom, 2 right, 3 top); they take effect at once and
// must only change while no item is in flight.
// An item (start_x, start_y, end_x, end_y) is taken at a rising edge where
// start is high and busy is low. Each item yields one result: done pulses
// for one cycle with visible and the clipped endpoints, which keep the
// caller's orientation and are all zero when nothing of the segment is left.
// Throughput is one item per cycle while busy is low: a four-stage front does
// ordering, rejects, interior tests and the exact intersection tests, a
// two-entry queue follows, and the back runs two pipelined dividers, one
// quotient bit per stage, for the start and end hit points, then the result
// registers. Since the receiver cannot hold results off, the back drains the
// queue every cycle and busy stays low in practice.
// Reset clears all valid flags and the rectangle to zero; no clearing pass.
// ----------------------------------------------------------------------------
module line_segment_rect_clipper import lsrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_idx,
	input  wire logic [COORD_BITS-1:0]        cfg_wdata,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic                              done,
	output logic                              visible,
	output logic signed [COORD_BITS-1:0]      clipped_start_x,
	output logic signed [COORD_BITS-1:0]      clipped_start_y,
	output logic signed [COORD_BITS-1:0]      clipped_end_x,
	output logic signed [COORD_BITS-1:0]      clipped_end_y
);
	localparam int EW = ent_bits(COORD_BITS);

	// Rectangle registers.
	logic signed [COORD_BITS-1:0] rect_left_q, rect_bottom_q, rect_right_q, rect_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_bottom_q <= '0;
			rect_right_q  <= '0;
			rect_top_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LEFT:   rect_left_q   <= cfg_wdata;
				REG_BOTTOM: rect_bottom_q <= cfg_wdata;
				REG_RIGHT:  rect_right_q  <= cfg_wdata;
				REG_TOP:    rect_top_q    <= cfg_wdata;
			endcase
		end
	end

	logic          q_wr, q_rd, q_full, q_empty;
	logic [EW-1:0] q_wdata, q_rdata;

	lsrc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.rect_left   (rect_left_q),
		.rect_bottom (rect_bottom_q),
		.rect_right  (rect_right_q),
		.rect_top    (rect_top_q),
		.q_wr        (q_wr),
		.q_data      (q_wdata),
		.q_full      (q_full)
	);

	lsrc_fifo #(.DW(EW)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	lsrc_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_data          (q_rdata),
		.q_empty         (q_empty),
		.q_rd            (q_rd),
		.rect_left       (rect_left_q),
		.rect_bottom     (rect_bottom_q),
		.rect_right      (rect_right_q),
		.rect_top        (rect_top_q),
		.done            (done),
		.visible         (visible),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y)
	);

endmodule
`default_nettype wire

// ----- rtl/core/lsrc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment clipper checker
// Port-level checks of result timing and of the invisible result encoding.
// ----------------------------------------------------------------------------
module lsrc_checker import lsrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic                  visible,
	input wire logic [COORD_BITS-1:0] clipped_start_x,
	input wire logic [COORD_BITS-1:0] clipped_start_y,
	input wire logic [COORD_BITS-1:0] clipped_end_x,
	input wire logic [COORD_BITS-1:0] clipped_end_y
);
	localparam int LAT = COORD_BITS + 7;

	// Every accepted item produces its result a fixed number of cycles later.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after accepted item");

	// A result strobe always traces back to an accepted item.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching item");

	// visible is only raised together with the strobe.
	a_vis_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !visible)
		else $error("visible outside a result cycle");

	// An invisible result carries all-zero endpoints.
	a_zero_invis: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> clipped_start_x == '0 && clipped_start_y == '0 &&
			clipped_end_x == '0 && clipped_end_y == '0)
		else $error("invisible result with nonzero endpoints");

endmodule

bind line_segment_rect_clipper lsrc_checker #(.COORD_BITS(COORD_BITS)) u_lsrc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.visible         (visible),
	.clipped_start_x (clipped_start_x),
	.clipped_start_y (clipped_start_y),
	.clipped_end_x   (clipped_end_x),
	.clipped_end_y   (clipped_end_y)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment clipper testbench
// Streams line segments into the clipper under several rectangles and
// compares every result with a typed expectation or a built-in clipping predictor.
// ----------------------------------------------------------------------------
module tb;
	import lsrc_pkg::*;

	localparam int W = 32;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 50;

	typedef logic signed [W-1:0] coord_t;
	typedef struct {
		coord_t x0, y0, x1, y1;
	} seg_t;
	typedef struct {
		logic   vis;
		coord_t sx, sy, ex, ey;
	} clip_t;
	typedef struct {
		seg_t  seg;
		bit    typed;
		clip_t res;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_idx = REG_LEFT;
	logic [W-1:0] cfg_wdata = '0;
	logic         start = 1'b0;
	coord_t       start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic         busy, done, visible;
	coord_t       clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;

	// Typed expectation that travels with the item being driven.
	bit    drv_typed = 1'b0;
	clip_t drv_res;

	// Rectangle as the predictor sees it.
	longint rc_left = 0, rc_bottom = 0, rc_right = 0, rc_top = 0;

	clip_t  pending_clips[$];
	int     errors = 0;
	int     segs_sent = 0;
	int     results_seen = 0;
	int     visible_seen = 0;
	int     quiet = 0;

	always #4 clk = ~clk;

	line_segment_rect_clipper DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.done(done), .visible(visible),
		.clipped_start_x(clipped_start_x), .clipped_start_y(clipped_start_y),
		.clipped_end_x(clipped_end_x), .clipped_end_y(clipped_end_y)
	);

	// ------------------------------------------------------------------------
	// Predictor. All arithmetic is exact: coordinates are widened to 64 bits
	// and the intersection products to 128 bits.
	// ------------------------------------------------------------------------

	// Edge at fixed coordinate f spanning a0 -> a1; segment starts at (sf, sa)
	// and moves by (df, da). Returns whether it hits, and the hit position along the edge in pos.
	function automatic bit edge_cross(input longint f, a0, a1, sf, sa, df, da,
			output longint pos);
		longint d1, t;
		logic signed [127:0] w_da, w_df, w_t, w_a0, w_sa, w_d1, num, den, quo;
		pos = 0;
		d1 = a1 - a0;
		t = f - sf;
		if (df == 0 || d1 == 0)
			return 1'b0;
		if (df > 0) begin
			if (t < 0 || t > df)
				return 1'b0;
		end else begin
			if (t > 0 || t < df)
				return 1'b0;
		end
		w_da = da; w_df = df; w_t = t; w_a0 = a0; w_sa = sa; w_d1 = d1;
		num = w_da * w_t - w_df * (w_a0 - w_sa);
		den = w_df * w_d1;
		if (den >= 0) begin
			if (num < 0 || num > den)
				return 1'b0;
		end else begin
			if (num > 0 || num < den)
				return 1'b0;
		end
		// Signed division truncates toward zero, as the hardware must.
		quo = num / w_df;
		pos = a0 + longint'(quo[63:0]);
		return 1'b1;
	endfunction

	function automatic bit edge_point(input logic [1:0] which,
			input longint sx, sy, ex, ey, output longint px, py);
		longint dx, dy, a;
		bit ok;
		dx = ex - sx;
		dy = ey - sy;
		px = 0;
		py = 0;
		case (which)
			E_TOP: begin
				ok = edge_cross(rc_top, rc_left, rc_right, sy, sx, dy, dx, a);
				px = a; py = rc_top;
			end
			E_RIGHT: begin
				ok = edge_cross(rc_right, rc_top, rc_bottom, sx, sy, dx, dy, a);
				px = rc_right; py = a;
			end
			E_BOTTOM: begin
				ok = edge_cross(rc_bottom, rc_right, rc_left, sy, sx, dy, dx, a);
				px = a; py = rc_bottom;
			end
			default: begin
				ok = edge_cross(rc_left, rc_bottom, rc_top, sx, sy, dx, dy, a);
				px = rc_left; py = a;
			end
		endcase
		return ok;
	endfunction

	// Edge list is packed two bits per edge, first edge in the low bits.
	function automatic bit first_edge(input logic [7:0] order, input int n,
			input longint sx, sy, ex, ey, output longint px, py);
		px = 0;
		py = 0;
		for (int i = 0; i < n; i++)
			if (edge_point(order[2*i +: 2], sx, sy, ex, ey, px, py))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit strictly_inside(input longint px, py);
		return rc_right > px && rc_left < px && rc_top > py && rc_bottom < py;
	endfunction

	// Clips a segment whose start is the lower-y point.
	function automatic bit clip_low_first(input longint sx, sy, ex, ey,
			output longint osx, osy, oex, oey);
		logic [7:0] all_edges, after_bot, after_lft, after_rgt;
		all_edges = {E_LEFT, E_BOTTOM, E_RIGHT, E_TOP};
		after_bot = {2'b00, E_RIGHT, E_LEFT, E_TOP};
		after_lft = {4'b0000, E_RIGHT, E_TOP};
		after_rgt = {4'b0000, E_LEFT, E_TOP};
		osx = 0; osy = 0; oex = 0; oey = 0;
		// Quick bounding rejects; the x test depends on the segment's direction.
		if (sy > rc_top || ey < rc_bottom)
			return 1'b0;
		if (ex >= sx) begin
			if (sx > rc_right || ex < rc_left)
				return 1'b0;
		end else begin
			if (sx < rc_left || ex > rc_right)
				return 1'b0;
		end
		if (strictly_inside(sx, sy)) begin
			osx = sx; osy = sy;
			if (strictly_inside(ex, ey)) begin
				oex = ex; oey = ey;
				return 1'b1;
			end
			return first_edge(all_edges, 4, sx, sy, ex, ey, oex, oey);
		end
		if (strictly_inside(ex, ey)) begin
			oex = ex; oey = ey;
			return first_edge(all_edges, 4, sx, sy, ex, ey, osx, osy);
		end
		if (sy < rc_bottom && edge_point(E_BOTTOM, sx, sy, ex, ey, osx, osy))
			return first_edge(after_bot, 3, sx, sy, ex, ey, oex, oey);
		if (edge_point(E_LEFT, sx, sy, ex, ey, osx, osy))
			return first_edge(after_lft, 2, sx, sy, ex, ey, oex, oey);
		if (edge_point(E_RIGHT, sx, sy, ex, ey, osx, osy))
			return first_edge(after_rgt, 2, sx, sy, ex, ey, oex, oey);
		return 1'b0;
	endfunction

	function automatic clip_t clip_segment(input seg_t s);
		clip_t  r;
		longint ax, ay, bx, by;
		bit     vis;
		if (s.y1 < s.y0)
			vis = clip_low_first(s.x1, s.y1, s.x0, s.y0, bx, by, ax, ay);
		else
			vis = clip_low_first(s.x0, s.y0, s.x1, s.y1, ax, ay, bx, by);
		r.vis = vis;
		r.sx = vis ? coord_t'(ax) : '0;
		r.sy = vis ? coord_t'(ay) : '0;
		r.ex = vis ? coord_t'(bx) : '0;
		r.ey = vis ? coord_t'(by) : '0;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Monitor: records expectations for accepted items, tracks register
	// writes, and checks each result against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		clip_t want;
		seg_t  seg;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LEFT:   rc_left = longint'(coord_t'(cfg_wdata));
					REG_BOTTOM: rc_bottom = longint'(coord_t'(cfg_wdata));
					REG_RIGHT:  rc_right = longint'(coord_t'(cfg_wdata));
					default:    rc_top = longint'(coord_t'(cfg_wdata));
				endcase
			end
			quiet++;
			if (start && !busy) begin
				seg = '{start_x, start_y, end_x, end_y};
				pending_clips.push_back(drv_typed ? drv_res : clip_segment(seg));
				quiet = 0;
			end
			if (done) begin
				quiet = 0;
				results_seen++;
				if (visible)
					visible_seen++;
				if (pending_clips.size() == 0) begin
					$error("result with no item outstanding");
					errors++;
				end else begin
					want = pending_clips.pop_front();
					if (visible !== want.vis) begin
						$error("visible: expected %0d, got %0d", want.vis, visible);
						errors++;
					end
					if (clipped_start_x !== want.sx) begin
						$error("clipped_start_x: expected %0d, got %0d", want.sx,
							clipped_start_x);
						errors++;
					end
					if (clipped_start_y !== want.sy) begin
						$error("clipped_start_y: expected %0d, got %0d", want.sy,
							clipped_start_y);
						errors++;
					end
					if (clipped_end_x !== want.ex) begin
						$error("clipped_end_x: expected %0d, got %0d", want.ex,
							clipped_end_x);
						errors++;
					end
					if (clipped_end_y !== want.ey) begin
						$error("clipped_end_y: expected %0d, got %0d", want.ey,
							clipped_end_y);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: a long stretch with nothing accepted and no result means the block hung.
	always @(posedge clk) begin
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driving tasks.
	// ------------------------------------------------------------------------

	// Waits until every expected result is back, then lets the pipeline
	// settle, since the rectangle may only change with nothing in flight.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_clips.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input longint value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= coord_t'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_rect(input longint l, b, r, t);
		drain();
		write_reg(REG_LEFT, l);
		write_reg(REG_BOTTOM, b);
		write_reg(REG_RIGHT, r);
		write_reg(REG_TOP, t);
		@(posedge clk);
	endtask

	// Drives one item and holds it until accepted. start stays high, so the
	// next item can follow back to back. idle_pct sets the chance of a gap.
	task automatic send_seg(input seg_t s, input bit typed, input clip_t res,
			input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1'b1;
		start_x <= s.x0;
		start_y <= s.y0;
		end_x <= s.x1;
		end_y <= s.y1;
		drv_typed <= typed;
		drv_res <= res;
		do @(posedge clk); while (busy);
		segs_sent++;
	endtask

	function automatic longint qf(input int n);
		return longint'(n) * 65536;
	endfunction

	// Picks a coordinate that favors the neighborhood of [lo, hi]: exact
	// edges, just inside, just outside, or anywhere in the full range.
	function automatic coord_t pick_coord(input longint a, b);
		longint lo, hi, span, v;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		span = hi - lo + 1;
		case ($urandom_range(9))
			0: v = lo;
			1: v = hi;
			2: v = lo + $urandom_range(2) - 1;
			3: v = hi + $urandom_range(2) - 1;
			4, 5: v = lo - span / 2 + longint'($urandom) % (2 * span);
			6, 7: v = lo + longint'($urandom) % span;
			default: v = longint'(coord_t'($urandom));
		endcase
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return coord_t'(v);
	endfunction

	function automatic seg_t random_seg();
		seg_t s;
		if ($urandom_range(9) == 0) begin
			s = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom)};
		end else begin
			s.x0 = pick_coord(rc_left, rc_right);
			s.y0 = pick_coord(rc_bottom, rc_top);
			s.x1 = pick_coord(rc_left, rc_right);
			s.y1 = pick_coord(rc_bottom, rc_top);
			// Axis-parallel and zero-length segments exercise the
			// parallel-edge rule.
			case ($urandom_range(7))
				0: s.y1 = s.y0;
				1: s.x1 = s.x0;
				2: begin s.x1 = s.x0; s.y1 = s.y0; end
				default: ;
			endcase
		end
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------------
	localparam coord_t CMIN = coord_t'(-64'sd2147483648);
	localparam coord_t CMAX = coord_t'(64'sd2147483647);

	initial begin
		row_t   table_rows[$];
		clip_t  none;
		seg_t   s;
		int     idle_pcts[4];
		longint rects[5][4];

		idle_pcts = '{0, 74, 0, 32};
		none = '{1'b0, '0, '0, '0, '0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset rectangle of zero size nothing can be visible.
		send_seg('{'0, '0, '0, '0}, 1'b1, none, 0);
		send_seg('{coord_t'(qf(-5)), coord_t'(qf(-5)), coord_t'(qf(5)),
			coord_t'(qf(5))}, 1'b1, none, 0);

		set_rect(qf(0), qf(0), qf(100), qf(100));

		// Directed rows. Typed rows are obvious from the rules: both ends
		// strictly inside pass unchanged, fully outside ones are all zero.
		table_rows = '{
			'{'{coord_t'(qf(10)), coord_t'(qf(10)), coord_t'(qf(90)),
				coord_t'(qf(90))}, 1'b1, '{1'b1, coord_t'(qf(10)),
				coord_t'(qf(10)), coord_t'(qf(90)), coord_t'(qf(90))}},
			'{'{coord_t'(qf(10)), coord_t'(qf(90)), coord_t'(qf(90)),
				coord_t'(qf(10))}, 1'b1, '{1'b1, coord_t'(qf(10)),
				coord_t'(qf(90)), coord_t'(qf(90)), coord_t'(qf(10))}},
			'{'{coord_t'(qf(50)), coord_t'(qf(50)), coord_t'(qf(50)),
				coord_t'(qf(50))}, 1'b1, '{1'b1, coord_t'(qf(50)),
				coord_t'(qf(50)), coord_t'(qf(50)), coord_t'(qf(50))}},
			'{'{coord_t'(qf(10)), coord_t'(qf(200)), coord_t'(qf(90)),
				coord_t'(qf(300))}, 1'b1, none},
			'{'{coord_t'(qf(-50)), coord_t'(qf(10)), coord_t'(qf(-20)),
				coord_t'(qf(90))}, 1'b1, none},
			'{'{coord_t'(qf(10)), coord_t'(qf(-90)), coord_t'(qf(90)),
				coord_t'(qf(-10))}, 1'b1, none},
			'{'{CMIN, CMIN, CMAX, CMAX}, 1'b0, none},
			'{'{CMAX, CMAX, CMIN, CMIN}, 1'b0, none},
			'{'{CMIN, CMAX, CMAX, CMIN}, 1'b0, none},
			'{'{coord_t'(qf(-50)), coord_t'(qf(50)), coord_t'(qf(150)),
				coord_t'(qf(50))}, 1'b0, none},
			'{'{coord_t'(qf(50)), coord_t'(qf(-50)), coord_t'(qf(50)),
				coord_t'(qf(150))}, 1'b0, none},
			'{'{coord_t'(qf(0)), coord_t'(qf(50)), coord_t'(qf(50)),
				coord_t'(qf(50))}, 1'b0, none},
			'{'{coord_t'(qf(150)), coord_t'(qf(150)), coord_t'(qf(150)),
				coord_t'(qf(150))}, 1'b0, none},
			'{'{coord_t'(qf(-10)), coord_t'(qf(-10)), coord_t'(qf(110)),
				coord_t'(qf(110))}, 1'b0, none},
			'{'{coord_t'(qf(50)), coord_t'(qf(50)), coord_t'(qf(150)),
				coord_t'(qf(80))}, 1'b0, none},
			'{'{coord_t'(qf(150)), coord_t'(qf(80)), coord_t'(qf(50)),
				coord_t'(qf(50))}, 1'b0, none},
			'{'{coord_t'(qf(50)), coord_t'(qf(-20)), coord_t'(qf(150)),
				coord_t'(qf(60))}, 1'b0, none},
			'{'{coord_t'(qf(-30)), coord_t'(qf(20)), coord_t'(qf(70)),
				coord_t'(qf(130))}, 1'b0, none},
			'{'{coord_t'(32'sh0003_8001), coord_t'(-32'sh0001_2345),
				coord_t'(32'sh0070_ffff), coord_t'(32'sh0066_6667)}, 1'b0, none},
			'{'{coord_t'(qf(0)), coord_t'(qf(0)), coord_t'(qf(100)),
				coord_t'(qf(100))}, 1'b0, none}
		};
		foreach (table_rows[i])
			send_seg(table_rows[i].seg, table_rows[i].typed, table_rows[i].res, 0);

		// Random phases, each under its own rectangle: extremes of the range, an
		// ordinary one, a degenerate one with corners swapped, a random one and a
		// zero-height one. Each phase starts only once the previous has drained.
		rects[0] = '{-64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
			64'sd2147483647};
		rects[1] = '{qf(-300), qf(-20), qf(400), qf(250)};
		rects[2] = '{qf(100), qf(80), qf(-100), qf(-80)};
		rects[3] = '{longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
			longint'(coord_t'($urandom)), longint'(coord_t'($urandom))};
		rects[4] = '{qf(-1), qf(7), qf(1), qf(7)};
		for (int p = 0; p < 5; p++) begin
			set_rect(rects[p][0], rects[p][1], rects[p][2], rects[p][3]);
			for (int i = 0; i < 390; i++) begin
				s = random_seg();
				send_seg(s, 1'b0, none, idle_pcts[p % 4]);
			end
		end

		drain();
		$display("Clipped %0d segments against 7 rectangles; %0d results, %0d visible.",
			segs_sent, results_seen, visible_seen);
		if (errors == 0 && pending_clips.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
